@@ hdl/pcan_pkg.sv @@
// Shared types, stage numbering and fixed-point constants for the PCAN gain block.
// No dependencies; every other file in hdl/ depends on this package.
package pcan_pkg;

   // Default sizes of the shrink stage
   localparam int SNR_BITS_DEFAULT    = 12;
   localparam int OUTPUT_BITS_DEFAULT = 6;

   // Field widths
   localparam int DATA_WIDTH       = 32;
   localparam int WORD_WIDTH       = 16;
   localparam int NORM_WIDTH       = 26;
   localparam int PROD_SHIFT_WIDTH = 6;
   localparam int PROD_SHIFT_RESET = 6;

   // Gain table, split into four banks by the low index bits
   localparam int TABLE_DEPTH    = 128;
   localparam int INDEX_WIDTH    = $clog2(TABLE_DEPTH);
   localparam int BANK_COUNT     = 4;
   localparam int BANK_SEL_WIDTH = $clog2(BANK_COUNT);
   localparam int BANK_DEPTH     = TABLE_DEPTH / BANK_COUNT;
   localparam int ROW_WIDTH      = $clog2(BANK_DEPTH);

   // Segment coefficients sit at 4*seg-6 (c0), +1 (c1), +2 (c2)
   localparam int BANK_C2 = 0;
   localparam int BANK_C0 = 2;
   localparam int BANK_C1 = 3;

   // Quadratic evaluation
   localparam int SEG_WIDTH   = 6;
   localparam int FRAC_BITS   = 10;
   localparam int COEF_SHIFT  = 5;
   localparam int ROUND_SHIFT = 15;
   localparam int ROUND_HALF  = 1 << 14;
   localparam int ACC_WIDTH   = 23;
   localparam int PROD_WIDTH  = DATA_WIDTH + WORD_WIDTH + 1;

   // Operation codes
   localparam logic OP_TABLE_WRITE = 1'b0;
   localparam logic OP_PROCESS     = 1'b1;

   // Pipeline stage numbering
   localparam int STG_INPUT  = 0;
   localparam int STG_COEF   = 1;
   localparam int STG_ACC    = 2;
   localparam int STG_GAIN   = 3;
   localparam int STG_PROD   = 4;
   localparam int STG_SNR    = 5;
   localparam int STG_OUT    = 6;
   localparam int NUM_STAGES = 7;

   typedef struct packed {
      logic                          op;
      logic [INDEX_WIDTH-1:0]        table_index;
      logic signed [WORD_WIDTH-1:0]  table_word;
      logic [DATA_WIDTH-1:0]         noise_level;
      logic [DATA_WIDTH-1:0]         energy;
      logic                          last_channel;
   } req_type;

   typedef struct packed {
      logic [NORM_WIDTH-1:0] normalized;
      logic                  frame_end;
   } rsp_type;

   // Per-stage load enables and valid bits
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
      logic [NUM_STAGES-1:0] valid;
   } pipe_ctl_type;

   // Table read result plus the channel data that travels with it
   typedef struct packed {
      logic [BANK_COUNT-1:0][WORD_WIDTH-1:0] bank_q;
      logic [FRAC_BITS-1:0]                  frac;
      logic                                  direct;
      logic [BANK_SEL_WIDTH-1:0]             direct_sel;
      logic [DATA_WIDTH-1:0]                 energy;
      logic                                  last;
   } coef_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] gain;
      logic [DATA_WIDTH-1:0] energy;
      logic                  last;
   } gain_type;

endpackage

@@ hdl/pcan_stream_if.sv @@
// Valid/ready stream interfaces for the request and response channels.
// Depends on pcan_pkg for the payload types.
interface pcan_req_if;
   logic              valid;
   logic              ready;
   pcan_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pcan_rsp_if;
   logic              valid;
   logic              ready;
   pcan_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/pcan_gain_table.sv @@
// Input stage, segment decode and the four-bank gain table with registered reads.
// Depends on pcan_pkg.
module pcan_gain_table (
   input  logic                   clock,
   input  pcan_pkg::pipe_ctl_type ctl,
   input  pcan_pkg::req_type      req_data,
   output logic                   s1_is_process,
   output pcan_pkg::coef_type     coef
);
   import pcan_pkg::*;

   typedef struct packed {
      req_type              item;
      logic [SEG_WIDTH-1:0] seg;
   } s1_type;

   // Position of the leading one, counted from 1; zero for zero
   function automatic logic [SEG_WIDTH-1:0] bit_length(input logic [DATA_WIDTH-1:0] x);
      logic [SEG_WIDTH-1:0] n;
      n = '0;
      for (int i = 0; i < DATA_WIDTH; i++) begin
         if (x[i]) begin
            n = SEG_WIDTH'(i + 1);
         end
      end
      return n;
   endfunction

   s1_type s1_ff, s1_in;

   logic                                 direct;
   logic [SEG_WIDTH-1:0]                 norm_sh;
   logic [DATA_WIDTH-1:0]                norm_x;
   logic [FRAC_BITS-1:0]                 frac;
   logic [ROW_WIDTH-1:0]                 seg_row_hi;
   logic [ROW_WIDTH-1:0]                 seg_row_lo;
   logic [BANK_COUNT-1:0][ROW_WIDTH-1:0] rd_row;
   logic                                 wr_en;
   logic [BANK_SEL_WIDTH-1:0]            wr_bank;
   logic [ROW_WIDTH-1:0]                 wr_row;
   logic [BANK_COUNT-1:0][WORD_WIDTH-1:0] q_all;

   logic [FRAC_BITS-1:0]      frac_ff;
   logic                      direct_ff;
   logic [BANK_SEL_WIDTH-1:0] direct_sel_ff;
   logic [DATA_WIDTH-1:0]     energy_ff;
   logic                      last_ff;

   // Capture the request beat with its segment number
   always_comb begin
      s1_in = '{item: req_data, seg: bit_length(req_data.noise_level)};
   end

   always_ff @(posedge clock) begin
      if (ctl.load[STG_INPUT]) begin
         s1_ff <= s1_in;
      end
   end

   assign s1_is_process = (s1_ff.item.op == OP_PROCESS);

   // Decode fraction and bank rows; estimates 0..2 read their entry directly
   always_comb begin
      direct = (s1_ff.item.noise_level[DATA_WIDTH-1:2] == '0) &&
               (s1_ff.item.noise_level[1:0] != 2'b11);
      norm_sh    = SEG_WIDTH'(DATA_WIDTH) - s1_ff.seg;
      norm_x     = s1_ff.item.noise_level << norm_sh;
      frac       = norm_x[DATA_WIDTH-2 -: FRAC_BITS];
      seg_row_hi = ROW_WIDTH'(s1_ff.seg - SEG_WIDTH'(1));
      seg_row_lo = ROW_WIDTH'(s1_ff.seg - SEG_WIDTH'(2));
      rd_row = '0;
      if (!direct) begin
         rd_row[BANK_C2] = seg_row_hi;
         rd_row[BANK_C0] = seg_row_lo;
         rd_row[BANK_C1] = seg_row_lo;
      end
   end

   // Write a table word as the write beat leaves the input stage
   assign wr_en   = ctl.valid[STG_INPUT] && ctl.load[STG_COEF] &&
                    (s1_ff.item.op == OP_TABLE_WRITE);
   assign wr_bank = s1_ff.item.table_index[BANK_SEL_WIDTH-1:0];
   assign wr_row  = s1_ff.item.table_index[INDEX_WIDTH-1:BANK_SEL_WIDTH];

   for (genvar b = 0; b < BANK_COUNT; b++) begin : g_bank
      logic [WORD_WIDTH-1:0] bank_ff [BANK_DEPTH];
      logic [WORD_WIDTH-1:0] q_ff;

      always_ff @(posedge clock) begin
         if (wr_en && (wr_bank == BANK_SEL_WIDTH'(b))) begin
            bank_ff[wr_row] <= s1_ff.item.table_word;
         end
         if (ctl.load[STG_COEF]) begin
            q_ff <= bank_ff[rd_row[b]];
         end
      end

      assign q_all[b] = q_ff;
   end

   // Carry channel data alongside the read
   always_ff @(posedge clock) begin
      if (ctl.load[STG_COEF]) begin
         frac_ff       <= frac;
         direct_ff     <= direct;
         direct_sel_ff <= s1_ff.item.noise_level[BANK_SEL_WIDTH-1:0];
         energy_ff     <= s1_ff.item.energy;
         last_ff       <= s1_ff.item.last_channel;
      end
   end

   assign coef = '{bank_q: q_all, frac: frac_ff, direct: direct_ff, direct_sel: direct_sel_ff,
                   energy: energy_ff, last: last_ff};

endmodule

@@ hdl/pcan_gain_interp.sv @@
// Two-stage evaluation of the piecewise-quadratic gain segment.
// Depends on pcan_pkg.
module pcan_gain_interp (
   input  logic                   clock,
   input  pcan_pkg::pipe_ctl_type ctl,
   input  pcan_pkg::coef_type     coef,
   output pcan_pkg::gain_type     gain_out
);
   import pcan_pkg::*;

   logic signed [WORD_WIDTH+FRAC_BITS:0] c2_prod;
   logic signed [ACC_WIDTH-1:0]          c2_term;
   logic signed [ACC_WIDTH-1:0]          c1_term;
   logic signed [ACC_WIDTH-1:0]          acc1_in;

   logic signed [ACC_WIDTH-1:0] acc1_ff;
   logic [WORD_WIDTH-1:0]       c0_ff;
   logic [WORD_WIDTH-1:0]       direct_gain_ff;
   logic                        direct_ff;
   logic [FRAC_BITS-1:0]        frac_ff;
   logic [DATA_WIDTH-1:0]       energy_ff;
   logic                        last_ff;

   logic signed [ACC_WIDTH+FRAC_BITS+1:0] quad_prod;
   logic signed [ACC_WIDTH+FRAC_BITS+1:0] quad_round;
   logic signed [19:0]                    quad_term;
   logic signed [19:0]                    quad_sum;
   logic [WORD_WIDTH-1:0]                 gain_in;

   logic [WORD_WIDTH-1:0] gain_ff;
   logic [DATA_WIDTH-1:0] energy2_ff;
   logic                  last2_ff;

   // First term: floor(c2*frac/32) + 32*c1
   always_comb begin
      c2_prod = $signed(coef.bank_q[BANK_C2]) * $signed({1'b0, coef.frac});
      c2_term = ACC_WIDTH'(c2_prod >>> COEF_SHIFT);
      c1_term = ACC_WIDTH'($signed(coef.bank_q[BANK_C1])) <<< COEF_SHIFT;
      acc1_in = c2_term + c1_term;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[STG_ACC]) begin
         acc1_ff        <= acc1_in;
         c0_ff          <= coef.bank_q[BANK_C0];
         direct_gain_ff <= coef.bank_q[coef.direct_sel];
         direct_ff      <= coef.direct;
         frac_ff        <= coef.frac;
         energy_ff      <= coef.energy;
         last_ff        <= coef.last;
      end
   end

   // Second term: round(acc*frac / 2^15) + c0, wrapped to 16 bits
   always_comb begin
      quad_prod  = acc1_ff * $signed({1'b0, frac_ff});
      quad_round = quad_prod + (ACC_WIDTH+FRAC_BITS+2)'(ROUND_HALF);
      quad_term  = 20'(quad_round >>> ROUND_SHIFT);
      quad_sum   = quad_term + 20'($signed(c0_ff));
      gain_in    = direct_ff ? direct_gain_ff : quad_sum[WORD_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.load[STG_GAIN]) begin
         gain_ff    <= gain_in;
         energy2_ff <= energy_ff;
         last2_ff   <= last_ff;
      end
   end

   assign gain_out = '{gain: gain_ff, energy: energy2_ff, last: last2_ff};

endmodule

@@ hdl/pcan_normalize.sv @@
// Energy times gain, programmable right shift and the square/linear shrink.
// Depends on pcan_pkg; the last stage is the response output register.
module pcan_normalize #(
   parameter int SNR_BITS    = pcan_pkg::SNR_BITS_DEFAULT,
   parameter int OUTPUT_BITS = pcan_pkg::OUTPUT_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  pcan_pkg::pipe_ctl_type                 ctl,
   input  logic [pcan_pkg::PROD_SHIFT_WIDTH-1:0]  prod_shift,
   input  pcan_pkg::gain_type                     gain_in,
   output pcan_pkg::rsp_type                      rsp_data
);
   import pcan_pkg::*;

   localparam int SqShift  = 2 + 2 * SNR_BITS - OUTPUT_BITS;
   localparam int DownGap  = (SNR_BITS >= OUTPUT_BITS) ? SNR_BITS - OUTPUT_BITS : 0;
   localparam int UpGap    = (SNR_BITS >= OUTPUT_BITS) ? 0 : OUTPUT_BITS - SNR_BITS;
   localparam int LowWidth = SNR_BITS + 1;
   localparam int WideBits = 2 * DATA_WIDTH;

   logic signed [PROD_WIDTH-1:0] prod_in;
   logic signed [PROD_WIDTH-1:0] prod_ff;
   logic                         last5_ff;

   logic [WideBits-1:0]   prod_wide;
   logic [DATA_WIDTH-1:0] snr_in;
   logic [DATA_WIDTH-1:0] snr_ff;
   logic                  last6_ff;

   logic [LowWidth-1:0]   low_x;
   logic                  is_low;
   logic [2*LowWidth-1:0] sq;
   logic [WideBits-1:0]   sq_ext;
   logic [NORM_WIDTH-1:0] low_val;
   logic [WideBits-1:0]   up_ext;
   logic [WideBits-1:0]   up_sh;
   logic [NORM_WIDTH-1:0] up_val;
   logic [NORM_WIDTH-1:0] norm_in;

   rsp_type out_ff;

   // Signed product; modulo 2^64 it is this value sign-extended
   assign prod_in = $signed({1'b0, gain_in.energy}) * $signed(gain_in.gain);

   always_ff @(posedge clock) begin
      if (ctl.load[STG_PROD]) begin
         prod_ff  <= prod_in;
         last5_ff <= gain_in.last;
      end
   end

   // Shift the 64-bit product and keep the low word
   always_comb begin
      prod_wide = {{(WideBits-PROD_WIDTH){prod_ff[PROD_WIDTH-1]}}, prod_ff};
      snr_in    = DATA_WIDTH'(prod_wide >> prod_shift);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[STG_SNR]) begin
         snr_ff   <= snr_in;
         last6_ff <= last5_ff;
      end
   end

   // Shrink: square below 2<<SNR_BITS, linear with offset above
   always_comb begin
      low_x   = snr_ff[LowWidth-1:0];
      is_low  = (snr_ff[DATA_WIDTH-1:LowWidth] == '0);
      sq      = low_x * low_x;
      sq_ext  = WideBits'(sq);
      low_val = NORM_WIDTH'(sq_ext >> SqShift);
      up_ext  = WideBits'(snr_ff);
      up_sh   = (SNR_BITS >= OUTPUT_BITS) ? (up_ext >> DownGap) : (up_ext << UpGap);
      up_val  = NORM_WIDTH'(up_sh) - NORM_WIDTH'(1 << OUTPUT_BITS);
      norm_in = is_low ? low_val : up_val;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[STG_OUT]) begin
         out_ff <= '{normalized: norm_in, frame_end: last6_ff};
      end
   end

   assign rsp_data = out_ff;

endmodule

@@ hdl/pcan_auto_gain_control_unit.sv @@
// A process beat passes the input, coef, acc, gain, prod, snr and out stages to its response.
// Throughput: one beat per cycle while the response side accepts; table-write beats leave after
// the input stage, no response. Stage load enables let input fill bubbles while a response waits.
// Reset clears all stage valid bits and sets the product shift to 6; table contents stay undefined.
// Depends on pcan_pkg, pcan_stream_if, pcan_gain_table, pcan_gain_interp, pcan_normalize.
module pcan_auto_gain_control_unit #(
   parameter int SNR_BITS    = pcan_pkg::SNR_BITS_DEFAULT,
   parameter int OUTPUT_BITS = pcan_pkg::OUTPUT_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   pcan_req_if.sink                              req_chan,
   pcan_rsp_if.source                            rsp_chan,
   input  logic                                  csr_wr_en,
   input  logic [pcan_pkg::PROD_SHIFT_WIDTH-1:0] csr_wr_data
);
   import pcan_pkg::*;

   logic [NUM_STAGES-1:0]       valid_ff, valid_in, load;
   logic [PROD_SHIFT_WIDTH-1:0] prod_shift_ff, prod_shift_in;
   logic                        s1_is_process;
   pipe_ctl_type                ctl;
   coef_type                    coef;
   gain_type                    gain;
   rsp_type                     rsp_data;

   // A stage loads when empty or when its beat moves on
   always_comb begin
      load[STG_OUT] = !valid_ff[STG_OUT] || rsp_chan.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   // Advance valid bits; drop table-write beats after the input stage
   always_comb begin
      valid_in = valid_ff;
      if (load[STG_INPUT]) begin
         valid_in[STG_INPUT] = req_chan.valid;
      end
      if (load[STG_COEF]) begin
         valid_in[STG_COEF] = valid_ff[STG_INPUT] && s1_is_process;
      end
      for (int k = STG_ACC; k < NUM_STAGES; k++) begin
         if (load[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   // Load the shift setting on a CSR write, else hold it
   assign prod_shift_in = csr_wr_en ? csr_wr_data : prod_shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         prod_shift_ff <= PROD_SHIFT_WIDTH'(PROD_SHIFT_RESET);
      end else begin
         valid_ff      <= valid_in;
         prod_shift_ff <= prod_shift_in;
      end
   end

   assign ctl = '{load: load, valid: valid_ff};

   pcan_gain_table u_table (
      .clock         (clock),
      .ctl           (ctl),
      .req_data      (req_chan.payload),
      .s1_is_process (s1_is_process),
      .coef          (coef)
   );

   pcan_gain_interp u_interp (
      .clock    (clock),
      .ctl      (ctl),
      .coef     (coef),
      .gain_out (gain)
   );

   pcan_normalize #(
      .SNR_BITS    (SNR_BITS),
      .OUTPUT_BITS (OUTPUT_BITS)
   ) u_normalize (
      .clock      (clock),
      .ctl        (ctl),
      .prod_shift (prod_shift_ff),
      .gain_in    (gain),
      .rsp_data   (rsp_data)
   );

   assign req_chan.ready   = load[STG_INPUT];
   assign rsp_chan.valid   = valid_ff[STG_OUT];
   assign rsp_chan.payload = rsp_data;

endmodule

@@ tb/pcan_auto_gain_control_unit_tb.sv @@
// Self-checking testbench for pcan_auto_gain_control_unit: loads the gain table, streams channel
// beats with random gaps and stalls, predicts each normalized value and checks every response.
// Depends on pcan_pkg, pcan_stream_if and the gain block RTL.
module pcan_auto_gain_control_unit_tb;
   import pcan_pkg::*;

   localparam int SNR_BITS     = SNR_BITS_DEFAULT;
   localparam int OUTPUT_BITS  = OUTPUT_BITS_DEFAULT;
   localparam int IDLE_LIMIT   = 1000;
   localparam int DRAIN_CYCLES = 20;
   localparam int CSR_SETTLE   = 10;
   localparam int LONG_HOLD    = 200;
   localparam int PHASE_BEATS  = 190;
   localparam int SHIFT_PHASES = 7;

   logic                        clock;
   logic                        reset;
   logic                        csr_wr_en;
   logic [PROD_SHIFT_WIDTH-1:0] csr_wr_data;

   pcan_req_if req_bus ();
   pcan_rsp_if rsp_bus ();

   pcan_auto_gain_control_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the gain table and the shift register
   logic signed [WORD_WIDTH-1:0] gain_words [TABLE_DEPTH];
   logic [PROD_SHIFT_WIDTH-1:0]  shift_setting;
   logic [PROD_SHIFT_WIDTH-1:0]  shift_plan [SHIFT_PHASES];

   req_type beats_to_send [$];
   rsp_type normalized_due [$];
   rsp_type expected_rsp;

   int error_count    = 0;
   int results_seen   = 0;
   int idle_cycles    = 0;
   int send_gap       = 0;
   int send_calm      = 0;
   int hold_left      = 0;
   int recv_calm      = 0;
   int next_long_hold = 300;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Piecewise-quadratic gain lookup for one noise estimate
   function automatic logic signed [WORD_WIDTH-1:0] segment_gain(logic [DATA_WIDTH-1:0] noise);
      int                     seg;
      logic [INDEX_WIDTH-1:0] base;
      logic [DATA_WIDTH-1:0]  aligned;
      logic signed [63:0]     frac;
      logic signed [63:0]     c0;
      logic signed [63:0]     c1;
      logic signed [63:0]     c2;
      logic signed [63:0]     acc;
      if (noise <= 2) return gain_words[noise[INDEX_WIDTH-1:0]];
      seg = 0;
      for (int b = 0; b < DATA_WIDTH; b++) if (noise[b]) seg = b + 1;
      base = INDEX_WIDTH'(4 * seg - 6);
      // take the 10 bits just below the leading one
      if (seg < FRAC_BITS + 1) aligned = noise << (FRAC_BITS + 1 - seg);
      else aligned = noise >> (seg - FRAC_BITS - 1);
      frac = 64'(aligned[FRAC_BITS-1:0]);
      c0 = gain_words[base];
      c1 = gain_words[base + 1];
      c2 = gain_words[base + 2];
      acc = (c2 * frac) >>> COEF_SHIFT;
      acc = acc + c1 * (1 << COEF_SHIFT);
      acc = acc * frac;
      acc = (acc + ROUND_HALF) >>> ROUND_SHIFT;
      acc = acc + c0;
      return acc[WORD_WIDTH-1:0];
   endfunction

   // Gain, 64-bit product, shift and shrink for one channel beat
   function automatic rsp_type normalize_channel(req_type beat);
      logic signed [WORD_WIDTH-1:0] gain;
      logic [63:0]                  product;
      logic [63:0]                  shifted;
      logic [63:0]                  v;
      rsp_type                      result;
      gain = segment_gain(beat.noise_level);
      product = 64'(beat.energy) * 64'(gain);
      shifted = product >> shift_setting;
      v = 64'(shifted[31:0]);
      if (v < (64'd2 << SNR_BITS)) begin
         v = (v * v) >> (2 + 2 * SNR_BITS - OUTPUT_BITS);
      end else begin
         if (SNR_BITS >= OUTPUT_BITS) v = v >> (SNR_BITS - OUTPUT_BITS);
         else v = v << (OUTPUT_BITS - SNR_BITS);
         v = v - (64'd1 << OUTPUT_BITS);
      end
      result.normalized = v[NORM_WIDTH-1:0];
      result.frame_end  = beat.last_channel;
      return result;
   endfunction

   function automatic req_type table_beat(int index, logic [WORD_WIDTH-1:0] word);
      req_type beat;
      beat.op           = OP_TABLE_WRITE;
      beat.table_index  = INDEX_WIDTH'(index);
      beat.table_word   = word;
      beat.noise_level  = $urandom;
      beat.energy       = $urandom;
      beat.last_channel = 1'($urandom_range(0, 1));
      return beat;
   endfunction

   function automatic req_type channel_beat(logic [DATA_WIDTH-1:0] noise,
                                            logic [DATA_WIDTH-1:0] energy, logic last);
      req_type beat;
      beat.op           = OP_PROCESS;
      beat.table_index  = INDEX_WIDTH'($urandom);
      beat.table_word   = WORD_WIDTH'($urandom);
      beat.noise_level  = noise;
      beat.energy       = energy;
      beat.last_channel = last;
      return beat;
   endfunction

   // Mostly spread over all bit lengths, now and then all ones
   function automatic logic [DATA_WIDTH-1:0] random_magnitude();
      if ($urandom_range(0, 9) == 0) return '1;
      return $urandom >> $urandom_range(0, 31);
   endfunction

   function automatic logic [WORD_WIDTH-1:0] random_word();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 16'h7FFF;
      if (pick == 1) return 16'h8000;
      if (pick < 6) return WORD_WIDTH'($urandom_range(0, 4095) - 2048);
      return WORD_WIDTH'($urandom);
   endfunction

   task automatic queue_random_beats(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 15) begin
            beats_to_send.push_back(table_beat($urandom_range(0, TABLE_DEPTH - 1), random_word()));
         end else if ($urandom_range(0, 9) == 0) begin
            beats_to_send.push_back(channel_beat($urandom_range(0, 2), random_magnitude(),
                                                 $urandom_range(0, 7) == 0));
         end else begin
            beats_to_send.push_back(channel_beat(random_magnitude(), random_magnitude(),
                                                 $urandom_range(0, 7) == 0));
         end
      end
   endtask

   // Idle length for either side; calm stretches give runs with no idling
   function automatic int idle_length(inout int calm_left);
      int pick;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) calm_left = $urandom_range(20, 80);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Block until every queued beat is sent and every response has arrived
   task automatic wait_until_drained();
      do @(negedge clock);
      while (beats_to_send.size() != 0 || req_bus.valid || normalized_due.size() != 0);
   endtask

   // Request driver: hold a beat until accepted, then apply it to the shadow state
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid) begin
            if (req_bus.payload.op == OP_TABLE_WRITE)
               gain_words[req_bus.payload.table_index] = req_bus.payload.table_word;
            else
               normalized_due.push_back(normalize_channel(req_bus.payload));
         end
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (beats_to_send.size() > 0) begin
            req_bus.payload <= beats_to_send.pop_front();
            req_bus.valid   <= 1'b1;
            send_gap = idle_length(send_calm);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response monitor: compare each beat with the oldest prediction, then pick ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (normalized_due.size() == 0) begin
               $error("response beat with no channel pending: normalized %0d, frame_end %0d",
                      rsp_bus.payload.normalized, rsp_bus.payload.frame_end);
               error_count++;
            end else begin
               expected_rsp = normalized_due.pop_front();
               if (rsp_bus.payload.normalized !== expected_rsp.normalized) begin
                  $error("normalized: expected %0d, actual %0d",
                         expected_rsp.normalized, rsp_bus.payload.normalized);
                  error_count++;
               end
               if (rsp_bus.payload.frame_end !== expected_rsp.frame_end) begin
                  $error("frame_end: expected %0d, actual %0d",
                         expected_rsp.frame_end, rsp_bus.payload.frame_end);
                  error_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (results_seen >= next_long_hold) begin
            // long hold-off so the pipeline backs up into the request side
            hold_left = LONG_HOLD - 1;
            next_long_hold += 700;
            rsp_bus.ready <= 1'b0;
         end else begin
            hold_left = idle_length(recv_calm);
            if (hold_left > 0) begin
               hold_left--;
               rsp_bus.ready <= 1'b0;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   // Watchdog: end the run if no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready   = 1'b0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      reset           = 1'b1;
      shift_setting   = PROD_SHIFT_WIDTH'(PROD_SHIFT_RESET);
      shift_plan = '{6'd0, 6'd63, 6'd32, 6'($urandom_range(1, 62)),
                     6'($urandom_range(1, 62)), 6'd20, 6'd6};

      // Fill every table entry before any channel reads it
      for (int i = 0; i < TABLE_DEPTH; i++) beats_to_send.push_back(table_beat(i, random_word()));

      // Table extremes: direct entries, overflowing top segment, highest index
      beats_to_send.push_back(table_beat(0, 16'h7FFF));
      beats_to_send.push_back(table_beat(1, 16'h8000));
      beats_to_send.push_back(table_beat(2, 16'h0000));
      for (int i = 122; i <= 124; i++) beats_to_send.push_back(table_beat(i, 16'h7FFF));
      beats_to_send.push_back(table_beat(127, 16'h8000));

      // Chosen channels: small estimates, segment edges, negative gain, gain overflow
      beats_to_send.push_back(channel_beat(0, 32'hFFFF_FFFF, 1'b0));
      beats_to_send.push_back(channel_beat(1, 32'hFFFF_FFFF, 1'b1));
      beats_to_send.push_back(channel_beat(1, 32'h0000_0001, 1'b0));
      beats_to_send.push_back(channel_beat(2, 32'hFFFF_FFFF, 1'b0));
      beats_to_send.push_back(channel_beat(3, 32'h1234_5678, 1'b0));
      beats_to_send.push_back(channel_beat(32'h0000_03FF, 32'h0000_00FF, 1'b0));
      beats_to_send.push_back(channel_beat(32'h0000_0400, 32'h0000_1000, 1'b0));
      beats_to_send.push_back(channel_beat(32'h0000_07FF, 32'h00FF_FFFF, 1'b0));
      beats_to_send.push_back(channel_beat(32'h0000_0800, 32'h0000_0003, 1'b1));
      beats_to_send.push_back(channel_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
      beats_to_send.push_back(channel_beat(32'h8000_0000, 32'h0000_0000, 1'b0));
      // rewrite a coefficient and read it on the very next beat
      beats_to_send.push_back(table_beat(6, 16'h0100));
      beats_to_send.push_back(channel_beat(7, 32'h0000_FFFF, 1'b1));

      queue_random_beats(PHASE_BEATS + 40);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Each phase drains the pipeline, moves the product shift to a new setting and queues new beats
      for (int p = 0; p < SHIFT_PHASES; p++) begin
         wait_until_drained();
         repeat (CSR_SETTLE) @(posedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= shift_plan[p];
         @(posedge clock);
         csr_wr_en <= 1'b0;
         shift_setting = shift_plan[p];
         @(negedge clock);
         queue_random_beats(PHASE_BEATS);
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && normalized_due.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
